// File: src/cffd_pkg.sv
// Shared types and constants for the checked fixed-frame deframer.
package cffd_pkg;

  localparam int POS_W    = 5;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic       ACT_BYTE    = 1'b0;
  localparam logic       ACT_CONSUME = 1'b1;

  localparam logic       REG_HEADER  = 1'b0;
  localparam logic       REG_FOOTER  = 1'b1;

  localparam logic [7:0] HEADER_RST  = 8'd170;
  localparam logic [7:0] FOOTER_RST  = 8'd85;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_BAD_FTR = 2'd2;
  localparam logic [1:0] STATUS_BAD_CHK = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               ready_res;
    logic [7:0]         detected;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [15:0]        frame_count;
    logic [1:0]         frame_status;
  } out_item_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic       consume;
    logic       hdr_hit;
    logic       ftr_hit;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// File: src/cffd_front.sv
// Front end: configuration registers, word classification and the word queue.
module cffd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  cffd_pkg::in_item_t in_data,
  output cffd_pkg::q_head_t q_head,
  input  logic              q_pop
);
  import cffd_pkg::*;

  logic [7:0]        header_r, header_nxt;
  logic [7:0]        footer_r, footer_nxt;
  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  q_entry_t          entry_in;

  always_comb begin
    header_nxt = header_r;
    footer_nxt = footer_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HEADER: header_nxt = cfg_wdata;
        REG_FOOTER: footer_nxt = cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    entry_in.consume = (in_data.action == ACT_CONSUME);
    entry_in.hdr_hit = (in_data.rx_byte == header_r);
    entry_in.ftr_hit = (in_data.rx_byte == footer_r);
    entry_in.data    = in_data.rx_byte;
  end

  assign in_ready     = (count_r != QCNT_W'(QDEPTH));
  assign push         = in_valid && in_ready;
  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      footer_r <= FOOTER_RST;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      header_r <= header_nxt;
      footer_r <= footer_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

// File: src/cffd_back.sv
// Back end: frame tracking, XOR check, held results and the result register.
module cffd_back #(
  parameter int FRAME_LEN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cffd_pkg::q_head_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cffd_pkg::out_item_t out_data
);
  import cffd_pkg::*;

  localparam logic [POS_W-1:0] XOR_END  = POS_W'(FRAME_LEN - 3);
  localparam logic [POS_W-1:0] CHK_POS  = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       check_r, check_nxt;
  logic [7:0]       pend_det_r, pend_det_nxt;
  logic [15:0]      pend_x_r, pend_x_nxt;
  logic [15:0]      pend_y_r, pend_y_nxt;
  logic [7:0]       held_det_r, held_det_nxt;
  logic [15:0]      held_x_r, held_x_nxt;
  logic [15:0]      held_y_r, held_y_nxt;
  logic [15:0]      count_r, count_nxt;
  logic             ready_r, ready_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic [1:0]       status;
  logic             rdy;
  q_entry_t         e;

  assign e     = q_head.entry;
  assign q_pop = q_head.valid && (!out_valid_r || out_ready);

  always_comb begin
    pos_nxt      = pos_r;
    xor_nxt      = xor_r;
    check_nxt    = check_r;
    pend_det_nxt = pend_det_r;
    pend_x_nxt   = pend_x_r;
    pend_y_nxt   = pend_y_r;
    held_det_nxt = held_det_r;
    held_x_nxt   = held_x_r;
    held_y_nxt   = held_y_r;
    count_nxt    = count_r;
    ready_nxt    = ready_r;
    status       = STATUS_NONE;
    rdy          = ready_r;

    if (e.consume) begin
      // report the flag as it stood, then clear it
      ready_nxt = 1'b0;
    end else if (pos_r == '0) begin
      if (e.hdr_hit) begin
        pos_nxt = POS_W'(1);
        xor_nxt = '0;
      end
    end else begin
      if (pos_r <= XOR_END) begin
        xor_nxt = xor_r ^ e.data;
      end
      case (pos_r)
        POS_W'(1): pend_det_nxt = e.data;
        POS_W'(2): pend_x_nxt   = {pend_x_r[15:8], e.data};
        POS_W'(3): pend_x_nxt   = {e.data, pend_x_r[7:0]};
        POS_W'(4): pend_y_nxt   = {pend_y_r[15:8], e.data};
        POS_W'(5): pend_y_nxt   = {e.data, pend_y_r[7:0]};
        default:   ;
      endcase
      if (pos_r == CHK_POS) begin
        check_nxt = e.data;
      end
      if (pos_r >= LAST_POS) begin
        pos_nxt = '0;
        if (!e.ftr_hit) begin
          status = STATUS_BAD_FTR;
        end else if (check_r != xor_r) begin
          status = STATUS_BAD_CHK;
        end else begin
          held_det_nxt = pend_det_r;
          held_x_nxt   = pend_x_r;
          held_y_nxt   = pend_y_r;
          count_nxt    = count_r + 16'd1;
          ready_nxt    = 1'b1;
          status       = STATUS_OK;
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
      rdy = ready_nxt;
    end

    out_nxt.ready_res    = rdy;
    out_nxt.detected     = held_det_nxt;
    out_nxt.x_coord      = $signed(held_x_nxt);
    out_nxt.y_coord      = $signed(held_y_nxt);
    out_nxt.frame_count  = count_nxt;
    out_nxt.frame_status = status;

    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      xor_r       <= '0;
      check_r     <= '0;
      pend_det_r  <= '0;
      pend_x_r    <= '0;
      pend_y_r    <= '0;
      held_det_r  <= '0;
      held_x_r    <= '1;
      held_y_r    <= '1;
      count_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        pos_r      <= pos_nxt;
        xor_r      <= xor_nxt;
        check_r    <= check_nxt;
        pend_det_r <= pend_det_nxt;
        pend_x_r   <= pend_x_nxt;
        pend_y_r   <= pend_y_nxt;
        held_det_r <= held_det_nxt;
        held_x_r   <= held_x_nxt;
        held_y_r   <= held_y_nxt;
        count_r    <= count_nxt;
        ready_r    <= ready_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/checked_fixed_frame_deframer_top.sv
// Top level of the checked fixed-frame deframer.
// Receives serial bytes (or consume words) one word per clock while the queue
// has room and returns one result word for each. A header byte starts a frame
// of FRAME_LEN bytes; the last byte must match the footer and the one before it
// the XOR of bytes 1 to FRAME_LEN-3. Accepted frames update the held detection
// byte, x, y, a wrapping frame counter and the ready flag. Sustained rate is one
// word per clock while the result side is ready, set by the state update of the
// frame tracker; a word's result passes through the four-word input queue and
// then the result register, and waits in either while the result side stalls.
// Header and footer are to be written by the user only while the block is
// idle; the block itself does not enforce it.
module checked_fixed_frame_deframer_top #(
  parameter int FRAME_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  cffd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cffd_pkg::out_item_t out_data
);
  import cffd_pkg::*;

  q_head_t q_head;
  logic    q_pop;

  cffd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  cffd_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_ok_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_status == STATUS_OK) |-> out_data.ready_res)
    else $error("accepted frame without ready flag");

  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_head.valid)
    else $error("input stalled with empty queue");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid && (!out_valid || out_ready))
    else $error("queue popped without room for the result");

  a_result_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("popped word produced no result");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the checked fixed-frame deframer.
`timescale 1ns / 100ps

module tb_top;
  import cffd_pkg::*;

  localparam int FRAME_LEN   = 8;
  localparam int QUIET_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic      cfg_index;
  logic [7:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  checked_fixed_frame_deframer_top #(
    .FRAME_LEN(FRAME_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5ns clk = ~clk;

  // Deframer state mirror
  logic [7:0]  hdr_val = HEADER_RST;
  logic [7:0]  ftr_val = FOOTER_RST;
  logic [4:0]  frm_pos = '0;
  logic [7:0]  run_xor = '0;
  logic [7:0]  chk_byte = '0;
  logic [7:0]  pend_det = '0;
  logic [15:0] pend_x = '0;
  logic [15:0] pend_y = '0;
  logic [7:0]  held_det = '0;
  logic [15:0] held_x = 16'hFFFF;
  logic [15:0] held_y = 16'hFFFF;
  logic [15:0] frame_cnt = '0;
  logic        fresh = 1'b0;

  out_item_t status_words_due[$];

  int error_count = 0;
  int words_sent = 0;
  int frames_ok = 0;
  int frames_bad_ftr = 0;
  int frames_bad_chk = 0;
  int consumes = 0;
  int settings_applied = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 30;
  int sink_stall_pct = 25;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 30) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) flag_error($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    if (r < 30) return 16'hFFFF;
    if (r < 35) return 16'h0000;
    return 16'($urandom());
  endfunction

  // Advance the deframer by one word and return the status word it owes.
  function automatic out_item_t deframe_word(input in_item_t w);
    out_item_t r;
    logic [1:0] st;
    logic was_fresh;
    st = STATUS_NONE;
    if (w.action == ACT_CONSUME) begin
      was_fresh = fresh;
      fresh = 1'b0;
    end else begin
      if (frm_pos == 5'd0) begin
        if (w.rx_byte == hdr_val) begin
          frm_pos = 5'd1;
          run_xor = 8'h00;
        end
      end else begin
        if (frm_pos <= FRAME_LEN - 3) run_xor ^= w.rx_byte;
        case (frm_pos)
          5'd1: pend_det = w.rx_byte;
          5'd2: pend_x[7:0] = w.rx_byte;
          5'd3: pend_x[15:8] = w.rx_byte;
          5'd4: pend_y[7:0] = w.rx_byte;
          5'd5: pend_y[15:8] = w.rx_byte;
          default: ;
        endcase
        if (frm_pos == FRAME_LEN - 2) chk_byte = w.rx_byte;
        if (frm_pos >= FRAME_LEN - 1) begin
          frm_pos = 5'd0;
          // footer error wins over checksum error
          if (w.rx_byte != ftr_val) begin
            st = STATUS_BAD_FTR;
          end else if (chk_byte != run_xor) begin
            st = STATUS_BAD_CHK;
          end else begin
            held_det = pend_det;
            held_x = pend_x;
            held_y = pend_y;
            frame_cnt = frame_cnt + 16'd1;
            fresh = 1'b1;
            st = STATUS_OK;
          end
        end else begin
          frm_pos = frm_pos + 5'd1;
        end
      end
      was_fresh = fresh;
    end
    r.ready_res = was_fresh;
    r.detected = held_det;
    r.x_coord = held_x;
    r.y_coord = held_y;
    r.frame_count = frame_cnt;
    r.frame_status = st;
    return r;
  endfunction

  task automatic send_word(input logic act, input logic [7:0] b);
    in_item_t w;
    out_item_t due;
    int gap;
    w.action = act;
    w.rx_byte = b;
    gap = pick_gap(send_gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    due = deframe_word(w);
    status_words_due.push_back(due);
    words_sent++;
    if (act == ACT_CONSUME) consumes++;
    case (due.frame_status)
      STATUS_OK:      frames_ok++;
      STATUS_BAD_FTR: frames_bad_ftr++;
      STATUS_BAD_CHK: frames_bad_chk++;
      default: ;
    endcase
  endtask

  // Drop valid; every path that is not another send goes through here.
  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    hold_input();
    while (status_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEADER) hdr_val = val;
    else ftr_val = val;
    settings_applied++;
  endtask

  task automatic apply_settings(input logic [7:0] h, input logic [7:0] f);
    drain_results();
    write_reg(REG_HEADER, h);
    write_reg(REG_FOOTER, f);
  endtask

  // Send the first cut bytes of a frame, optionally corrupted, with
  // consume words mixed in between bytes.
  task automatic send_frame(input logic [7:0] det, input logic [15:0] x,
                            input logic [15:0] y, input bit bad_chk,
                            input bit bad_ftr, input int cut, input int mix_pct);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] sum;
    sum = 8'h00;
    fb[0] = hdr_val;
    fb[1] = det;
    fb[2] = x[7:0];
    fb[3] = x[15:8];
    fb[4] = y[7:0];
    fb[5] = y[15:8];
    for (int i = 6; i <= FRAME_LEN - 3; i++) fb[i] = 8'($urandom_range(255));
    for (int i = 1; i <= FRAME_LEN - 3; i++) sum ^= fb[i];
    fb[FRAME_LEN-2] = bad_chk ? sum ^ 8'($urandom_range(1, 255)) : sum;
    fb[FRAME_LEN-1] = bad_ftr ? ftr_val ^ 8'($urandom_range(1, 255)) : ftr_val;
    for (int i = 0; i < cut; i++) begin
      if (i > 0 && $urandom_range(99) < mix_pct)
        send_word(ACT_CONSUME, 8'($urandom_range(255)));
      send_word(ACT_BYTE, fb[i]);
    end
  endtask

  task automatic test_reset_state();
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_CONSUME, 8'h00);
  endtask

  task automatic test_framing_cases();
    // header value inside the frame, coordinate extremes
    send_frame(8'hFF, {8'h80, hdr_val}, 16'h7FFF, 0, 0, FRAME_LEN, 0);
    send_word(ACT_CONSUME, 8'hA5);
    // footer and checksum both wrong
    send_frame(8'h00, 16'h0000, 16'h0000, 1, 1, FRAME_LEN, 0);
    send_word(ACT_CONSUME, 8'h5A);
  endtask

  task automatic test_back_to_back();
    int save_gap;
    int save_stall;
    save_gap = send_gap_pct;
    save_stall = sink_stall_pct;
    send_gap_pct = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < 7; i++)
      send_frame(8'($urandom), pick_coord(), pick_coord(), i == 3, i == 5, FRAME_LEN, 0);
    send_word(ACT_CONSUME, 8'h00);
    send_word(ACT_CONSUME, 8'hFF);
    send_gap_pct = save_gap;
    sink_stall_pct = save_stall;
  endtask

  task automatic test_pause_mid_frame();
    logic [7:0] fb [FRAME_LEN];
    fb[0] = hdr_val;
    for (int i = 1; i <= 5; i++) fb[i] = 8'($urandom);
    fb[FRAME_LEN-2] = fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5];
    fb[FRAME_LEN-1] = ftr_val;
    for (int i = 0; i < 4; i++) send_word(ACT_BYTE, fb[i]);
    // stop mid frame until every owed word is back
    drain_results();
    for (int i = 4; i < FRAME_LEN; i++) send_word(ACT_BYTE, fb[i]);
    send_word(ACT_CONSUME, 8'($urandom));
  endtask

  task automatic test_random_traffic(input int n);
    int start;
    int kind;
    start = words_sent;
    while (words_sent - start < n) begin
      kind = $urandom_range(99);
      if (kind < 55)
        send_frame(8'($urandom), pick_coord(), pick_coord(), 0, 0, FRAME_LEN, 5);
      else if (kind < 63)
        send_frame(8'($urandom), pick_coord(), pick_coord(), 1, 0, FRAME_LEN, 5);
      else if (kind < 70)
        send_frame(8'($urandom), pick_coord(), pick_coord(), 0, 1, FRAME_LEN, 5);
      else if (kind < 73)
        send_frame(8'($urandom), pick_coord(), pick_coord(), 1, 1, FRAME_LEN, 5);
      else if (kind < 78)
        send_frame(8'($urandom), pick_coord(), pick_coord(), 0, 0,
                   $urandom_range(1, FRAME_LEN - 1), 5);
      else if (kind < 88)
        send_word(ACT_CONSUME, 8'($urandom));
      else if (kind < 98)
        send_word(ACT_BYTE, 8'($urandom));
      else
        drain_results();
    end
  endtask

  task automatic test_register_settings();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_settings(8'h00, 8'hFF);
        1: apply_settings(8'hFF, 8'h00);
        2: apply_settings(8'h5A, 8'h5A);
        6: apply_settings(HEADER_RST, FOOTER_RST);
        default: apply_settings(8'($urandom), 8'($urandom));
      endcase
      test_random_traffic(40);
    end
  endtask

  // Result side: random back-pressure
  initial begin : sink_pacing
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
        hold_left = pick_gap(sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_words_due.size() == 0) begin
        flag_error("result word with nothing due");
      end else begin
        want = status_words_due.pop_front();
        check_field("ready_res", 16'(out_data.ready_res), 16'(want.ready_res));
        check_field("detected", 16'(out_data.detected), 16'(want.detected));
        check_field("x_coord", out_data.x_coord, want.x_coord);
        check_field("y_coord", out_data.y_coord, want.y_coord);
        check_field("frame_count", out_data.frame_count, want.frame_count);
        check_field("frame_status", 16'(out_data.frame_status), 16'(want.frame_status));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_HEADER;
    cfg_wdata = 8'h00;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_framing_cases();
    test_back_to_back();
    test_pause_mid_frame();
    test_register_settings();
    test_random_traffic(200);

    drain_results();
    repeat (4) @(posedge clk);
    if (status_words_due.size() != 0)
      flag_error($sformatf("%0d result words never arrived", status_words_due.size()));

    $display("Covered %0d words: %0d frames accepted, %0d bad footer, %0d bad checksum,",
             words_sent, frames_ok, frames_bad_ftr, frames_bad_chk);
    $display("  %0d consume words, %0d register writes, %0d errors",
             consumes, settings_applied, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cffd_pkg.sv
src/cffd_front.sv
src/cffd_back.sv
src/checked_fixed_frame_deframer_top.sv
tb/sv/tb_top.sv
